FILE: rtl/core/sync_header_frame_deframer_assert.svh
// ----------------------------------------------------------------------------
// sync_header_frame_deframer assertion macros
// shared property templates, clocked on clk with reset rst_n
// ----------------------------------------------------------------------------
`ifndef SYNC_HEADER_FRAME_DEFRAMER_ASSERT_SVH
`define SYNC_HEADER_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define SHFD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication
`define SHFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

FILE: rtl/core/shfd_pkg.sv
// ----------------------------------------------------------------------------
// shfd_pkg
// types and constants shared by the frame deframer controller and datapath
// ----------------------------------------------------------------------------
package shfd_pkg;

    localparam int MAX_PAYLOAD = 16;
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int POS_W       = 4;
    localparam int CNT_W       = 16;

    localparam logic [7:0]       HDR_FIRST  = 8'hAA;
    localparam logic [7:0]       HDR_SECOND = 8'h55;
    localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};

    typedef enum logic [2:0] {
        ST_HDR1,
        ST_HDR2,
        ST_CMD,
        ST_LEN,
        ST_PAY,
        ST_SUM,
        ST_REPLAY
    } state_t;

    typedef enum logic [1:0] {
        EV_OK  = 2'd0,
        EV_SUM = 2'd1,
        EV_HDR = 2'd2,
        EV_LEN = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        OUT_HDR,
        OUT_LEN,
        OUT_SUMERR,
        OUT_EMPTY,
        OUT_PAYLOAD
    } out_sel_t;

    typedef struct packed {
        logic     cap_command;
        logic     cap_length;
        logic     clr_length;
        logic     wr_payload;
        logic     rd_first;
        logic     rd_step;
        logic     out_load;
        out_sel_t out_sel;
        logic     inc_framing;
        logic     inc_sum;
    } ctl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic is_hdr1;
        logic is_hdr2;
        logic len_over;
        logic len_zero;
        logic held_len_zero;
        logic sum_match;
        logic fill_done;
        logic replay_done;
    } dp_status_t;

endpackage

FILE: rtl/core/shfd_ctrl.sv
// ----------------------------------------------------------------------------
// shfd_ctrl
// frame parse state machine, issues datapath commands per accepted byte and per replay beat
// ----------------------------------------------------------------------------
module shfd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  shfd_pkg::dp_status_t   status,
    output shfd_pkg::ctl_cmd_t     cmd
);
    import shfd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HDR1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        in_ready   = (state_reg != ST_REPLAY) && status.out_free;
        accept     = in_valid && in_ready;
        state_next = state_reg;
        cmd        = '0;
        cmd.out_sel = OUT_HDR;
        case (state_reg)
            ST_HDR1:
            begin
                if (accept && status.is_hdr1)
                begin
                    state_next = ST_HDR2;
                end
            end
            ST_HDR2:
            begin
                if (accept)
                begin
                    if (status.is_hdr2)
                    begin
                        state_next = ST_CMD;
                    end
                    else
                    begin
                        // any other byte is a framing error; a repeated first header keeps waiting for the second
                        cmd.inc_framing = 1'b1;
                        cmd.out_load    = 1'b1;
                        cmd.out_sel     = OUT_HDR;
                        state_next      = status.is_hdr1 ? ST_HDR2 : ST_HDR1;
                    end
                end
            end
            ST_CMD:
            begin
                if (accept)
                begin
                    cmd.cap_command = 1'b1;
                    state_next      = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (accept)
                begin
                    if (status.len_over)
                    begin
                        cmd.clr_length  = 1'b1;
                        cmd.inc_framing = 1'b1;
                        cmd.out_load    = 1'b1;
                        cmd.out_sel     = OUT_LEN;
                        state_next      = ST_HDR1;
                    end
                    else
                    begin
                        cmd.cap_length = 1'b1;
                        state_next     = status.len_zero ? ST_SUM : ST_PAY;
                    end
                end
            end
            ST_PAY:
            begin
                if (accept)
                begin
                    cmd.wr_payload = 1'b1;
                    if (status.fill_done)
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                if (accept)
                begin
                    if (!status.sum_match)
                    begin
                        cmd.inc_sum  = 1'b1;
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OUT_SUMERR;
                        state_next   = ST_HDR1;
                    end
                    else if (status.held_len_zero)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OUT_EMPTY;
                        state_next   = ST_HDR1;
                    end
                    else
                    begin
                        cmd.rd_first = 1'b1;
                        state_next   = ST_REPLAY;
                    end
                end
            end
            ST_REPLAY:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_PAYLOAD;
                    cmd.rd_step  = 1'b1;
                    if (status.replay_done)
                    begin
                        state_next = ST_HDR1;
                    end
                end
            end
            default:
            begin
                state_next = ST_HDR1;
            end
        endcase
    end

endmodule

FILE: rtl/core/shfd_datapath.sv
// ----------------------------------------------------------------------------
// shfd_datapath
// frame fields, running checksum, payload memory, error counters, output register
// ----------------------------------------------------------------------------
module shfd_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [7:0]                        rx_byte,
    input  shfd_pkg::ctl_cmd_t                cmd,
    output shfd_pkg::dp_status_t              status,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        event_res,
    output logic [7:0]                        command,
    output logic [shfd_pkg::LEN_W-1:0]        length,
    output logic [shfd_pkg::POS_W-1:0]        position,
    output logic [7:0]                        data,
    output logic                              last,
    output logic [shfd_pkg::CNT_W-1:0]        framing_error_total,
    output logic [shfd_pkg::CNT_W-1:0]        sum_error_total
);
    import shfd_pkg::*;

    logic [7:0]        payload_mem [MAX_PAYLOAD];
    logic [7:0]        rd_data_reg;
    logic [7:0]        held_cmd_reg;
    logic [LEN_W-1:0]  held_len_reg;
    logic [LEN_W-1:0]  fill_reg;
    logic [POS_W-1:0]  idx_reg;
    logic [POS_W-1:0]  idx_next;
    logic [7:0]        sum_reg;
    logic [CNT_W-1:0]  framing_reg;
    logic [CNT_W-1:0]  framing_next;
    logic [CNT_W-1:0]  sumerr_reg;
    logic [CNT_W-1:0]  sumerr_next;
    logic              out_valid_reg;

    logic [1:0]        ev_reg;
    logic [7:0]        ocmd_reg;
    logic [LEN_W-1:0]  olen_reg;
    logic [POS_W-1:0]  opos_reg;
    logic [7:0]        odata_reg;
    logic              olast_reg;
    logic [CNT_W-1:0]  ofram_reg;
    logic [CNT_W-1:0]  osum_reg;

    assign idx_next     = idx_reg + POS_W'(1);
    assign framing_next = (cmd.inc_framing && framing_reg != CNT_MAX)
                          ? framing_reg + CNT_W'(1) : framing_reg;
    assign sumerr_next  = (cmd.inc_sum && sumerr_reg != CNT_MAX)
                          ? sumerr_reg + CNT_W'(1) : sumerr_reg;

    always_comb
    begin
        status.out_free      = !out_valid_reg || out_ready;
        status.is_hdr1       = (rx_byte == HDR_FIRST);
        status.is_hdr2       = (rx_byte == HDR_SECOND);
        status.len_over      = (rx_byte > 8'(MAX_PAYLOAD));
        status.len_zero      = (rx_byte == 8'd0);
        status.held_len_zero = (held_len_reg == '0);
        status.sum_match     = (rx_byte == sum_reg);
        status.fill_done     = ({1'b0, fill_reg} + (LEN_W+1)'(1)) >= {1'b0, held_len_reg};
        status.replay_done   = ({{(LEN_W-POS_W){1'b0}}, idx_reg} + LEN_W'(1)) == held_len_reg;
    end

    // payload store, written while filling, read one entry ahead of replay
    always_ff @(posedge clk)
    begin
        if (cmd.wr_payload)
        begin
            payload_mem[fill_reg[ADDR_W-1:0]] <= rx_byte;
        end
        if (cmd.rd_first)
        begin
            rd_data_reg <= payload_mem[0];
        end
        else if (cmd.rd_step)
        begin
            rd_data_reg <= payload_mem[idx_next[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cmd_reg  <= '0;
            held_len_reg  <= '0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            sum_reg       <= '0;
            framing_reg   <= '0;
            sumerr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            framing_reg <= framing_next;
            sumerr_reg  <= sumerr_next;
            if (cmd.cap_command)
            begin
                held_cmd_reg <= rx_byte;
                sum_reg      <= rx_byte;
            end
            if (cmd.cap_length)
            begin
                held_len_reg <= rx_byte[LEN_W-1:0];
                sum_reg      <= 8'(sum_reg + rx_byte);
                fill_reg     <= '0;
            end
            if (cmd.clr_length)
            begin
                held_len_reg <= '0;
                fill_reg     <= '0;
            end
            if (cmd.wr_payload)
            begin
                sum_reg  <= 8'(sum_reg + rx_byte);
                fill_reg <= fill_reg + LEN_W'(1);
            end
            if (cmd.rd_first)
            begin
                idx_reg <= '0;
            end
            else if (cmd.rd_step)
            begin
                idx_reg <= idx_next;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output beat register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            ofram_reg <= framing_next;
            osum_reg  <= sumerr_next;
            opos_reg  <= '0;
            odata_reg <= '0;
            olast_reg <= 1'b1;
            case (cmd.out_sel)
                OUT_HDR:
                begin
                    ev_reg   <= EV_HDR;
                    ocmd_reg <= '0;
                    olen_reg <= '0;
                end
                OUT_LEN:
                begin
                    ev_reg   <= EV_LEN;
                    ocmd_reg <= held_cmd_reg;
                    olen_reg <= '0;
                end
                OUT_SUMERR:
                begin
                    ev_reg   <= EV_SUM;
                    ocmd_reg <= held_cmd_reg;
                    olen_reg <= held_len_reg;
                end
                OUT_EMPTY:
                begin
                    ev_reg   <= EV_OK;
                    ocmd_reg <= held_cmd_reg;
                    olen_reg <= '0;
                end
                OUT_PAYLOAD:
                begin
                    ev_reg    <= EV_OK;
                    ocmd_reg  <= held_cmd_reg;
                    olen_reg  <= held_len_reg;
                    opos_reg  <= idx_reg;
                    odata_reg <= rd_data_reg;
                    olast_reg <= status.replay_done;
                end
                default:
                begin
                    ev_reg   <= EV_OK;
                    ocmd_reg <= '0;
                    olen_reg <= '0;
                end
            endcase
        end
    end

    assign out_valid           = out_valid_reg;
    assign event_res           = ev_reg;
    assign command             = ocmd_reg;
    assign length              = olen_reg;
    assign position            = opos_reg;
    assign data                = odata_reg;
    assign last                = olast_reg;
    assign framing_error_total = ofram_reg;
    assign sum_error_total     = osum_reg;

endmodule

FILE: rtl/core/sync_header_frame_deframer.sv
// ----------------------------------------------------------------------------
// sync_header_frame_deframer
// byte-serial parser for 0xAA 0x55 / command / length / payload / checksum frames
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   --------------------   ---------------------------------------------
//  input     in_valid / in_ready    rx_byte
//  output    out_valid / out_ready  event_res command length position data last
//                                   framing_error_total sum_error_total
//
//  one received byte is taken per cycle while parsing and the output register is free
//  a good checksum replays the stored payload from the payload memory, one beat
//  per cycle while the sink takes beats (its one read port)
//  reset clears the parse state, held fields and both error counters
//  a stalled output beat holds the input until the output register frees up
//
module sync_header_frame_deframer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        rx_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        event_res,
    output logic [7:0]                        command,
    output logic [shfd_pkg::LEN_W-1:0]        length,
    output logic [shfd_pkg::POS_W-1:0]        position,
    output logic [7:0]                        data,
    output logic                              last,
    output logic [shfd_pkg::CNT_W-1:0]        framing_error_total,
    output logic [shfd_pkg::CNT_W-1:0]        sum_error_total
);
    import shfd_pkg::*;

    `include "sync_header_frame_deframer_assert.svh"

    ctl_cmd_t   cmd;
    dp_status_t status;

    // parse controller: header hunt, field capture, replay sequencing
    shfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: running checksum, payload memory, counters, output beat register
    shfd_datapath u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .rx_byte             (rx_byte),
        .cmd                 (cmd),
        .status              (status),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .event_res           (event_res),
        .command             (command),
        .length              (length),
        .position            (position),
        .data                (data),
        .last                (last),
        .framing_error_total (framing_error_total),
        .sum_error_total     (sum_error_total)
    );

    // a waiting beat is never overwritten
    `SHFD_ASSERT_IMPLY(a_no_overwrite, out_valid && !out_ready, !cmd.out_load)
    // every counted error reports an event beat
    `SHFD_ASSERT_IMPLY(a_err_reports, cmd.inc_framing || cmd.inc_sum, cmd.out_load)
    // replay runs without gaps while the sink takes beats
    `SHFD_ASSERT_NEXT(a_replay_steady, out_valid && out_ready && !last, out_valid)

endmodule
